// ===== src/lkhc_pkg.sv =====
// lkhc_pkg: shared types and constants for the LRU keyed handle cache.
// Request/response beat layouts, command codes, controller/datapath link.
// No dependencies.
package lkhc_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // command codes; code 3 is a no-op
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] new_handle;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] handle;
        logic                evicted;
        logic [KEY_W-1:0]    evicted_key;
        logic [HANDLE_W-1:0] evicted_handle;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic take_item;
        logic clear_all;
        logic cnt_clr;
        logic scan_step;
        logic decide;
        logic sweep_step;
        logic insert;
        logic load_out;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic in_cache_op;
        logic in_clear;
        logic cnt_done;
        logic dec_sweep;
        logic ins_pending;
        logic out_free;
    } sts_t;

endpackage

// ===== src/lru_keyed_handle_cache.sv =====
// lru_keyed_handle_cache: fully associative LRU cache, 64-bit key -> handle.
// Each beat scans every slot, plus an age sweep over every slot on a get hit or an insert.
// Clear and no-op skip the scan; a lookup or a get miss without insert skips the sweep.
// A beat waits in its done state while the output reg still holds an unaccepted response.
// Response valid rises in the same cycle req_ready returns; one beat is processed at a time.
// Async active-low reset: all slots invalid, count 0, capacity_limit 16.
module lru_keyed_handle_cache #(
    parameter int DEPTH       = lkhc_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = lkhc_pkg::HANDLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  lkhc_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output lkhc_pkg::rsp_t             rsp,
    input  logic                       cfg_wr_en,
    input  logic [lkhc_pkg::CAP_W-1:0] cfg_wr_data
);

    // Flow per request beat:
    //   scan   - read every slot, find first key match, oldest valid slot
    //            and first free slot
    //   decide - evict the oldest on a full miss, latch the response
    //   sweep  - rewrite ages: touched entry to 0 and younger ones +1 on a
    //            hit, or every valid entry +1 ahead of an insert
    //   insert - write key/handle with age 0 into the free slot
    //   done   - park the response in the output register
    // The output register lets the next request be taken while a response
    // beat still waits on rsp_ready.

    lkhc_pkg::ctl_t ctl;
    lkhc_pkg::sts_t sts;

    lkhc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    lkhc_datapath #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .sts         (sts),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

    // an accepted request keeps the input closed until its response is parked
    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req_ready stayed high after a request beat");

    // the sequencer drives one datapath step at a time
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ctl.take_item, ctl.scan_step, ctl.decide, ctl.sweep_step,
                    ctl.insert, ctl.load_out}) <= 1)
        else $error("overlapping datapath commands");

    // eviction happens only on a miss
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.evicted |-> !rsp.hit)
        else $error("eviction reported on a hit");

    // no eviction, no evicted payload
    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.evicted |-> rsp.evicted_key == '0 && rsp.evicted_handle == '0)
        else $error("evicted fields nonzero without eviction");

endmodule

// ===== src/lkhc_datapath.sv =====
// lkhc_datapath: slot memory, valid bits, scan trackers, LRU age update,
// result and output registers. Driven by lkhc_ctrl commands.
// Depends on lkhc_pkg.
module lkhc_datapath #(
    parameter int DEPTH       = lkhc_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = lkhc_pkg::HANDLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lkhc_pkg::req_t                 req,
    input  logic                           cfg_wr_en,
    input  logic [lkhc_pkg::CAP_W-1:0]     cfg_wr_data,
    input  lkhc_pkg::ctl_t                 ctl,
    output lkhc_pkg::sts_t                 sts,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output lkhc_pkg::rsp_t                 rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AGE_W = IDX_W;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CNT_W > lkhc_pkg::CAP_W) ? CNT_W : lkhc_pkg::CAP_W;
    localparam int HB_IN = (HANDLE_BITS < lkhc_pkg::HANDLE_W) ? HANDLE_BITS
                                                               : lkhc_pkg::HANDLE_W;

    typedef struct packed {
        logic [lkhc_pkg::KEY_W-1:0] key;
        logic [HANDLE_BITS-1:0]     hnd;
        logic [AGE_W-1:0]           age;
    } slot_t;

    slot_t mem [DEPTH];

    // control state
    logic [DEPTH-1:0]          valid_reg;
    logic [CNT_W-1:0]          live_cnt_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [lkhc_pkg::CAP_W-1:0] cap_reg;
    logic                      scan_eval_reg;
    logic                      sweep_eval_reg;
    logic                      out_valid_reg;
    logic                      ins_reg;
    logic                      touch_reg;
    logic                      match_found_reg;
    logic                      old_found_reg;
    logic                      free_found_reg;

    // payload
    lkhc_pkg::req_t            item_reg;
    lkhc_pkg::rsp_t            res_reg;
    lkhc_pkg::rsp_t            out_reg;
    slot_t                     rd_data_reg;
    logic [IDX_W-1:0]          rd_idx_reg;
    logic [IDX_W-1:0]          match_idx_reg;
    logic [AGE_W-1:0]          match_age_reg;
    logic [HANDLE_BITS-1:0]    match_hnd_reg;
    logic [IDX_W-1:0]          old_idx_reg;
    logic [AGE_W-1:0]          old_age_reg;
    logic [lkhc_pkg::KEY_W-1:0] old_key_reg;
    logic [HANDLE_BITS-1:0]    old_hnd_reg;
    logic [IDX_W-1:0]          free_idx_reg;
    logic [IDX_W-1:0]          ins_idx_reg;

    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic                      cnt_done;
    logic                      ev_valid;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    slot_t                     wr_data;
    logic                      sw_wr;
    logic [AGE_W-1:0]          sw_age;

    logic [LIM_W-1:0]          cap_ext;
    logic [LIM_W-1:0]          lim;
    logic                      is_get;
    logic                      miss_get;
    logic                      do_evict;
    logic [CNT_W-1:0]          cnt_after;
    logic [HANDLE_BITS-1:0]    nh;
    logic                      do_ins;
    logic                      do_touch;
    logic [IDX_W-1:0]          ins_idx;
    lkhc_pkg::rsp_t            dec_res;

    assign cnt_done = (cnt_reg == CNT_W'(DEPTH));
    assign rd_en    = (ctl.scan_step || ctl.sweep_step) && !cnt_done;
    assign rd_addr  = cnt_reg[IDX_W-1:0];
    assign ev_valid = valid_reg[rd_idx_reg];

    // effective limit: 0 acts as 1, above DEPTH acts as DEPTH
    always_comb
    begin
        cap_ext = LIM_W'(cap_reg);
        if (cap_ext == '0)
        begin
            lim = LIM_W'(1);
        end
        else if (cap_ext > LIM_W'(DEPTH))
        begin
            lim = LIM_W'(DEPTH);
        end
        else
        begin
            lim = cap_ext;
        end
    end

    always_comb
    begin
        is_get    = (item_reg.command == lkhc_pkg::CMD_GET);
        miss_get  = is_get && !match_found_reg;
        do_evict  = miss_get && (LIM_W'(live_cnt_reg) >= lim) && old_found_reg;
        cnt_after = live_cnt_reg - CNT_W'(do_evict);
        nh        = HANDLE_BITS'(item_reg.new_handle[HB_IN-1:0]);
        do_ins    = miss_get && (nh != '0) && (LIM_W'(cnt_after) < lim);
        do_touch  = is_get && match_found_reg;
        // the evicted slot is free again and may sit below the first free one
        if (do_evict && (!free_found_reg || (old_idx_reg < free_idx_reg)))
        begin
            ins_idx = old_idx_reg;
        end
        else
        begin
            ins_idx = free_idx_reg;
        end

        dec_res         = '0;
        dec_res.hit     = match_found_reg;
        dec_res.evicted = do_evict;
        if (match_found_reg)
        begin
            dec_res.handle = lkhc_pkg::HANDLE_W'(match_hnd_reg[HB_IN-1:0]);
        end
        else if (do_ins)
        begin
            dec_res.handle = lkhc_pkg::HANDLE_W'(nh[HB_IN-1:0]);
        end
        if (do_evict)
        begin
            dec_res.evicted_key    = old_key_reg;
            dec_res.evicted_handle = lkhc_pkg::HANDLE_W'(old_hnd_reg[HB_IN-1:0]);
        end
    end

    // age update during the sweep
    always_comb
    begin
        sw_wr  = 1'b0;
        sw_age = rd_data_reg.age;
        if (touch_reg)
        begin
            if (rd_idx_reg == match_idx_reg)
            begin
                sw_wr  = 1'b1;
                sw_age = '0;
            end
            else if (ev_valid && (rd_data_reg.age < match_age_reg))
            begin
                sw_wr  = 1'b1;
                sw_age = rd_data_reg.age + AGE_W'(1);
            end
        end
        else if (ev_valid)
        begin
            sw_wr  = 1'b1;
            sw_age = rd_data_reg.age + AGE_W'(1);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg;
        wr_data = rd_data_reg;
        if (ctl.insert)
        begin
            wr_en       = 1'b1;
            wr_addr     = ins_idx_reg;
            wr_data.key = item_reg.key;
            wr_data.hnd = HANDLE_BITS'(item_reg.new_handle[HB_IN-1:0]);
            wr_data.age = '0;
        end
        else if (sweep_eval_reg && sw_wr)
        begin
            wr_en       = 1'b1;
            wr_data.age = sw_age;
        end
    end

    // slot memory: one read, one write per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        rd_idx_reg <= rd_addr;
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            live_cnt_reg    <= '0;
            cnt_reg         <= '0;
            cap_reg         <= lkhc_pkg::CAP_RESET;
            scan_eval_reg   <= 1'b0;
            sweep_eval_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            ins_reg         <= 1'b0;
            touch_reg       <= 1'b0;
            match_found_reg <= 1'b0;
            old_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end

            if (ctl.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (rd_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            scan_eval_reg  <= rd_en && ctl.scan_step;
            sweep_eval_reg <= rd_en && ctl.sweep_step;

            if (ctl.take_item)
            begin
                match_found_reg <= 1'b0;
                old_found_reg   <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else if (scan_eval_reg)
            begin
                if (ev_valid && (rd_data_reg.key == item_reg.key))
                begin
                    match_found_reg <= 1'b1;
                end
                if (ev_valid)
                begin
                    old_found_reg <= 1'b1;
                end
                if (!ev_valid)
                begin
                    free_found_reg <= 1'b1;
                end
            end

            if (ctl.clear_all)
            begin
                valid_reg    <= '0;
                live_cnt_reg <= '0;
            end
            else if (ctl.decide)
            begin
                ins_reg      <= do_ins;
                touch_reg    <= do_touch;
                live_cnt_reg <= cnt_after;
                if (do_evict)
                begin
                    valid_reg[old_idx_reg] <= 1'b0;
                end
            end
            else if (ctl.insert)
            begin
                valid_reg[ins_idx_reg] <= 1'b1;
                live_cnt_reg           <= live_cnt_reg + CNT_W'(1);
            end

            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.take_item)
        begin
            item_reg <= req;
            res_reg  <= '0;
        end
        if (ctl.decide)
        begin
            res_reg     <= dec_res;
            ins_idx_reg <= ins_idx;
        end
        if (scan_eval_reg)
        begin
            if (ev_valid && (rd_data_reg.key == item_reg.key) && !match_found_reg)
            begin
                match_idx_reg <= rd_idx_reg;
                match_age_reg <= rd_data_reg.age;
                match_hnd_reg <= rd_data_reg.hnd;
            end
            if (ev_valid && (!old_found_reg || (rd_data_reg.age > old_age_reg)))
            begin
                old_idx_reg <= rd_idx_reg;
                old_age_reg <= rd_data_reg.age;
                old_key_reg <= rd_data_reg.key;
                old_hnd_reg <= rd_data_reg.hnd;
            end
            if (!ev_valid && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
        if (ctl.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    always_comb
    begin
        sts.in_cache_op = (req.command == lkhc_pkg::CMD_GET)
                       || (req.command == lkhc_pkg::CMD_LOOKUP);
        sts.in_clear    = (req.command == lkhc_pkg::CMD_CLEAR);
        sts.cnt_done    = cnt_done;
        sts.dec_sweep   = do_touch || do_ins;
        sts.ins_pending = ins_reg;
        sts.out_free    = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ===== src/lkhc_ctrl.sv =====
// lkhc_ctrl: sequencer for the cache: scan, decide, age sweep, insert, result.
// Issues lkhc_pkg::ctl_t commands and reads lkhc_pkg::sts_t status.
// Depends on lkhc_pkg.
module lkhc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lkhc_pkg::sts_t sts,
    output lkhc_pkg::ctl_t ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SWEEP,
        ST_INSERT,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.take_item = 1'b1;
                    ctl.cnt_clr   = 1'b1;
                    ctl.clear_all = sts.in_clear;
                    state_next    = sts.in_cache_op ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.cnt_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                ctl.decide  = 1'b1;
                ctl.cnt_clr = 1'b1;
                state_next  = sts.dec_sweep ? ST_SWEEP : ST_DONE;
            end
            ST_SWEEP:
            begin
                ctl.sweep_step = 1'b1;
                if (sts.cnt_done)
                begin
                    state_next = sts.ins_pending ? ST_INSERT : ST_DONE;
                end
            end
            ST_INSERT:
            begin
                ctl.insert = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== verif/lkhc_scoreboard.sv =====
// lkhc_scoreboard: expected-response tracking for the LRU keyed handle cache.
// Holds a cycle-free copy of the slot store, ages and capacity limit.
// Depends on lkhc_pkg (beat layouts, command codes, widths).
`timescale 1ns / 1ps

package lkhc_sb_pkg;

    // expected responses in flight; the block never holds more than two
    localparam int DUE_CAP = 8;

    class lru_cache_scoreboard;

        bit                            slot_live [lkhc_pkg::DEPTH_DEF];
        logic [lkhc_pkg::KEY_W-1:0]    slot_key  [lkhc_pkg::DEPTH_DEF];
        logic [lkhc_pkg::HANDLE_W-1:0] slot_hnd  [lkhc_pkg::DEPTH_DEF];
        int unsigned                   slot_age  [lkhc_pkg::DEPTH_DEF];
        int unsigned                   live_cnt;
        logic [lkhc_pkg::CAP_W-1:0]    cap_reg;
        lkhc_pkg::rsp_t                rsp_due [DUE_CAP];
        int unsigned                   due_head;
        int unsigned                   due_tail;
        int unsigned                   due_cnt;
        int unsigned                   errors;

        function new();
            foreach (slot_live[i])
            begin
                slot_live[i] = 1'b0;
                slot_key[i]  = '0;
                slot_hnd[i]  = '0;
                slot_age[i]  = 0;
            end
            live_cnt = 0;
            cap_reg  = lkhc_pkg::CAP_RESET;
            due_head = 0;
            due_tail = 0;
            due_cnt  = 0;
            errors   = 0;
        endfunction

        function void set_limit(input logic [lkhc_pkg::CAP_W-1:0] v);
            cap_reg = v;
        endfunction

        // 0 behaves as 1, anything past DEPTH as DEPTH
        function int unsigned eff_limit();
            if (cap_reg == 0)
                return 1;
            if (cap_reg > lkhc_pkg::DEPTH_DEF)
                return lkhc_pkg::DEPTH_DEF;
            return cap_reg;
        endfunction

        function int find_key(input logic [lkhc_pkg::KEY_W-1:0] k);
            foreach (slot_live[i])
                if (slot_live[i] && slot_key[i] == k)
                    return i;
            return -1;
        endfunction

        // hit slot goes to age 0, younger live slots age by one
        function void promote(input int s);
            int unsigned a;
            a = slot_age[s];
            foreach (slot_live[i])
                if (slot_live[i] && i != s && slot_age[i] < a)
                    slot_age[i]++;
            slot_age[s] = 0;
        endfunction

        function int oldest_slot();
            int best;
            best = -1;
            foreach (slot_live[i])
                if (slot_live[i] && (best < 0 || slot_age[i] > slot_age[best]))
                    best = i;
            return best;
        endfunction

        function lkhc_pkg::rsp_t apply_request(input lkhc_pkg::req_t r);
            lkhc_pkg::rsp_t o;
            int             s;
            int             free_slot;
            int unsigned    lim;
            o = '0;
            case (r.command)
                lkhc_pkg::CMD_GET, lkhc_pkg::CMD_LOOKUP:
                begin
                    s = find_key(r.key);
                    if (s >= 0)
                    begin
                        o.hit    = 1'b1;
                        o.handle = slot_hnd[s];
                        if (r.command == lkhc_pkg::CMD_GET)
                            promote(s);
                    end
                    else if (r.command == lkhc_pkg::CMD_GET)
                    begin
                        lim = eff_limit();
                        if (live_cnt >= lim && live_cnt > 0)
                        begin
                            s = oldest_slot();
                            if (s >= 0)
                            begin
                                o.evicted        = 1'b1;
                                o.evicted_key    = slot_key[s];
                                o.evicted_handle = slot_hnd[s];
                                slot_live[s]     = 1'b0;
                                slot_age[s]      = 0;
                                live_cnt--;
                            end
                        end
                        if (r.new_handle != 0 && live_cnt < lim)
                        begin
                            free_slot = -1;
                            foreach (slot_live[i])
                                if (!slot_live[i] && free_slot < 0)
                                    free_slot = i;
                            if (free_slot >= 0)
                            begin
                                foreach (slot_live[i])
                                    if (slot_live[i])
                                        slot_age[i]++;
                                slot_live[free_slot] = 1'b1;
                                slot_key[free_slot]  = r.key;
                                slot_hnd[free_slot]  = r.new_handle;
                                slot_age[free_slot]  = 0;
                                live_cnt++;
                                o.handle = r.new_handle;
                            end
                        end
                    end
                end
                lkhc_pkg::CMD_CLEAR:
                begin
                    foreach (slot_live[i])
                    begin
                        slot_live[i] = 1'b0;
                        slot_age[i]  = 0;
                    end
                    live_cnt = 0;
                end
                default: ;
            endcase
            return o;
        endfunction

        function void note_request(input lkhc_pkg::req_t r);
            lkhc_pkg::rsp_t e;
            e = apply_request(r);
            if (due_cnt == DUE_CAP)
            begin
                $display("%0t: too many outstanding requests, expected at most %0d, got %0d",
                         $time, DUE_CAP, due_cnt + 1);
                errors++;
                return;
            end
            rsp_due[due_tail] = e;
            due_tail = (due_tail + 1) % DUE_CAP;
            due_cnt++;
        endfunction

        function int unsigned pending();
            return due_cnt;
        endfunction

        function void cmp_field(input string nm, input logic [63:0] exp,
                                input logic [63:0] got);
            if (got !== exp)
            begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, nm, exp, got);
                errors++;
            end
        endfunction

        function void check_response(input lkhc_pkg::rsp_t got);
            lkhc_pkg::rsp_t exp;
            if (due_cnt == 0)
            begin
                $display("%0t: response beat with nothing outstanding, expected none, got %h",
                         $time, got);
                errors++;
                return;
            end
            exp = rsp_due[due_head];
            due_head = (due_head + 1) % DUE_CAP;
            due_cnt--;
            cmp_field("hit", exp.hit, got.hit);
            cmp_field("handle", exp.handle, got.handle);
            cmp_field("evicted", exp.evicted, got.evicted);
            cmp_field("evicted_key", exp.evicted_key, got.evicted_key);
            cmp_field("evicted_handle", exp.evicted_handle, got.evicted_handle);
        endfunction

    endclass

endpackage

// ===== verif/tb.sv =====
// tb: top-level bench for lru_keyed_handle_cache.
// Drives request beats with bursty timing, stalls responses, checks each one.
// Depends on lkhc_pkg, lkhc_sb_pkg (verif/lkhc_scoreboard.sv) and the RTL.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF       = 4;      // 8 ns period
    localparam int RESET_CYCLES   = 7;
    // Slowest beat is a get-miss with insert (scan, decide, sweep, insert), plus
    // the long response hold below; the watchdog limit is far beyond that.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;    // one long receiver back-off
    localparam int HOLD_AFTER     = 150;    // ... after this many responses
    localparam int SETTLE         = 8;      // quiet cycles before a config write
    localparam int DRAIN          = 2 * lkhc_pkg::DEPTH_DEF + 10;
    localparam int PHASE_ITEMS    = 100;
    localparam int N_PHASES       = 10;
    localparam int POOL_MAX       = lkhc_pkg::DEPTH_DEF + 8;

    // command 3 has no package name; the block treats it as a no-op
    localparam logic [lkhc_pkg::CMD_W-1:0] CMD_NOP = 2'd3;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       req_valid   = 1'b0;
    logic                       req_ready;
    lkhc_pkg::req_t             req         = '0;
    logic                       rsp_valid;
    logic                       rsp_ready   = 1'b0;
    lkhc_pkg::rsp_t             rsp;
    logic                       cfg_wr_en   = 1'b0;
    logic [lkhc_pkg::CAP_W-1:0] cfg_wr_data = '0;

    lkhc_sb_pkg::lru_cache_scoreboard sb = new();

    int burst_left   = 0;   // beats left in the current sender burst
    int results_seen = 0;
    int stall_cycles = 0;

    always #CLK_HALF clk = ~clk;

    lru_keyed_handle_cache u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Monitors. Signals are read right after the edge, i.e. the values the
    // block saw at that edge. The request side updates the predictor at the
    // moment a beat is taken; the response side pops and compares.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (req_valid && req_ready)
            sb.note_request(req);
        if (rsp_valid && rsp_ready)
        begin
            sb.check_response(rsp);
            results_seen++;
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Response side. Segments of random length, each with its own stall
    // pattern: always ready, coin flip, or one cycle in four. Once, after
    // HOLD_AFTER responses, ready stays low for one long back-off while the
    // sender keeps offering, so the block backs up and drops req_ready.
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int seg;
        int tick;
        bit held;
        held = 1'b0;
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(8, 64);
            repeat (seg)
            begin
                @(posedge clk);
                tick++;
                if (!held && results_seen >= HOLD_AFTER)
                begin
                    held = 1'b1;
                    rsp_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    default: rsp_ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    function automatic logic [lkhc_pkg::KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Request side. Beats go out in bursts; between bursts valid drops for
    // a random gap, though some bursts run straight into the next. Inside a
    // burst valid stays high and only the payload moves on.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [lkhc_pkg::CMD_W-1:0] cmd,
                             input logic [lkhc_pkg::KEY_W-1:0] k,
                             input logic [lkhc_pkg::HANDLE_W-1:0] nh);
        lkhc_pkg::req_t beat;
        int             gap;
        beat.command    = cmd;
        beat.key        = k;
        beat.new_handle = nh;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Capacity writes only with the block idle: stop offering, let the
    // monitor log the last beat, let every outstanding response come back,
    // then SETTLE quiet cycles.
    task automatic write_limit(input logic [lkhc_pkg::CAP_W-1:0] v);
        req_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        sb.set_limit(v);
        cfg_wr_en <= 1'b0;
    endtask

    // Random phase: keys mostly from a pool a bit larger than the effective
    // limit, so gets both hit and evict; the rest are fresh random keys.
    // Cache contents carry over from the previous phase, so a lower limit
    // exercises the shrink-by-one path.
    task automatic run_phase(input logic [lkhc_pkg::CAP_W-1:0] limit_val, input int n_items);
        logic [lkhc_pkg::KEY_W-1:0]    pool [POOL_MAX];
        int                            pool_n;
        int                            lim;
        int                            pick;
        logic [lkhc_pkg::CMD_W-1:0]    cmd;
        logic [lkhc_pkg::KEY_W-1:0]    k;
        logic [lkhc_pkg::HANDLE_W-1:0] nh;
        write_limit(limit_val);
        lim = (limit_val == 0) ? 1 :
              (limit_val > lkhc_pkg::DEPTH_DEF) ? lkhc_pkg::DEPTH_DEF : int'(limit_val);
        pool_n = lim + $urandom_range(1, 8);
        for (int i = 0; i < pool_n; i++)
            pool[i] = rand_key();
        if ($urandom_range(0, 1) == 1)
            pool[0] = '0;
        pool[1] = '1;
        repeat (n_items)
        begin
            pick = $urandom_range(0, 99);
            cmd = (pick < 60) ? lkhc_pkg::CMD_GET : (pick < 96) ? lkhc_pkg::CMD_LOOKUP :
                  (pick < 98) ? lkhc_pkg::CMD_CLEAR : CMD_NOP;
            k = ($urandom_range(0, 9) == 0) ? rand_key() : pool[$urandom_range(0, pool_n - 1)];
            pick = $urandom_range(0, 9);
            nh = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
            send_beat(cmd, k, nh);
        end
    endtask

    initial
    begin
        logic [lkhc_pkg::KEY_W-1:0] dk [9];
        logic [lkhc_pkg::CAP_W-1:0] limits [N_PHASES];
        foreach (dk[i])
            dk[i] = rand_key();
        limits = '{5'd16, 5'd5, 5'd17, 5'd1, 5'd3, 5'd0, 5'd12, 5'd31, 5'd8, 5'd16};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed, reset limit of 16 ---
        send_beat(lkhc_pkg::CMD_LOOKUP, '0, $urandom);        // lookup miss on empty cache
        send_beat(lkhc_pkg::CMD_GET, '0, '1);                  // insert, max handle
        send_beat(lkhc_pkg::CMD_GET, '1, '0);                  // failed creation, not full
        send_beat(lkhc_pkg::CMD_LOOKUP, '0, $urandom);        // lookup hit
        send_beat(lkhc_pkg::CMD_GET, '0, $urandom);           // get hit
        send_beat(lkhc_pkg::CMD_GET, '1, 32'd1);               // insert max key
        send_beat(CMD_NOP, rand_key(), $urandom);             // unused command
        send_beat(lkhc_pkg::CMD_CLEAR, rand_key(), $urandom); // clear all
        send_beat(lkhc_pkg::CMD_LOOKUP, '0, $urandom);        // gone after clear

        // --- limit 2: eviction order, hit reorder, failed create when full ---
        write_limit(5'd2);
        send_beat(lkhc_pkg::CMD_GET, dk[0], 32'h11);
        send_beat(lkhc_pkg::CMD_GET, dk[1], 32'h22);
        send_beat(lkhc_pkg::CMD_GET, dk[2], 32'h33);           // evicts dk[0]
        send_beat(lkhc_pkg::CMD_LOOKUP, dk[0], $urandom);
        send_beat(lkhc_pkg::CMD_GET, dk[1], $urandom);        // dk[1] now most recent
        send_beat(lkhc_pkg::CMD_GET, dk[3], '0);               // evicts dk[2], inserts nothing
        send_beat(lkhc_pkg::CMD_GET, dk[4], 32'h55);

        // --- limit lowered below the count: shrink by one per miss ---
        write_limit(5'd1);
        send_beat(lkhc_pkg::CMD_GET, dk[5], 32'h66);           // evicts, still full, handle 0
        send_beat(lkhc_pkg::CMD_GET, dk[6], 32'h77);           // evicts, then inserts
        write_limit(5'd0);                                     // behaves as 1
        send_beat(lkhc_pkg::CMD_GET, dk[7], 32'h88);
        write_limit(5'd31);                                    // behaves as DEPTH
        send_beat(lkhc_pkg::CMD_GET, dk[8], 32'h99);

        // --- random phases over a spread of limits ---
        foreach (limits[i])
            run_phase(limits[i], PHASE_ITEMS);

        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
src/lkhc_pkg.sv
src/lkhc_datapath.sv
src/lkhc_ctrl.sv
src/lru_keyed_handle_cache.sv
verif/lkhc_scoreboard.sv
verif/tb.sv
